/* rtl/core/spfa_pkg.sv */
// ----------------------------------------------------------------------------
// spfa_pkg
// Shared types and constants of the SPI flash AAI program sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spfa_pkg;

  localparam int unsigned SECTOR_BYTES_DEF = 4096;
  localparam int unsigned MAX_SECTORS_DEF  = 1024;
  localparam int unsigned ADDR_BITS_DEF    = 24;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned LEN_W  = 23;
  localparam int unsigned OFF_W  = 22;
  localparam int unsigned STAT_W = 8;
  localparam int unsigned OP_W   = 8;

  // Fixed-point scale of the sector-count reciprocal.
  localparam int unsigned RECIP_SHIFT = 24;

  localparam int unsigned STATUS_BUSY_BIT = 0;

  localparam logic ACT_START = 1'b0;

  localparam logic [OP_W-1:0] OP_WRSR   = 8'h01;
  localparam logic [OP_W-1:0] OP_WRDI   = 8'h04;
  localparam logic [OP_W-1:0] OP_RDSR   = 8'h05;
  localparam logic [OP_W-1:0] OP_WREN   = 8'h06;
  localparam logic [OP_W-1:0] OP_SERASE = 8'h20;
  localparam logic [OP_W-1:0] OP_EWSR   = 8'h50;
  localparam logic [OP_W-1:0] OP_AAI    = 8'hAD;

  localparam logic [STAT_W-1:0] SR_UNLOCK = 8'h00;
  localparam logic [STAT_W-1:0] SR_LOCK   = 8'h1C;

  localparam logic [1:0] OUT_OK       = 2'd0;
  localparam logic [1:0] OUT_BAD_LEN  = 2'd1;
  localparam logic [1:0] OUT_LINK_ERR = 2'd2;

  typedef enum logic [11:0] {
    PH_IDLE    = 12'b0000_0000_0001,
    PH_U_EWSR  = 12'b0000_0000_0010,
    PH_U_WRSR  = 12'b0000_0000_0100,
    PH_E_WREN  = 12'b0000_0000_1000,
    PH_E_ERASE = 12'b0000_0001_0000,
    PH_E_POLL  = 12'b0000_0010_0000,
    PH_P_WREN  = 12'b0000_0100_0000,
    PH_P_AAI   = 12'b0000_1000_0000,
    PH_P_POLL  = 12'b0001_0000_0000,
    PH_P_WRDI  = 12'b0010_0000_0000,
    PH_L_EWSR  = 12'b0100_0000_0000,
    PH_L_WRSR  = 12'b1000_0000_0000
  } spfa_phase_e;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] base_addr;
    logic [LEN_W-1:0]  image_bytes;
    logic              link_error;
    logic [STAT_W-1:0] status_byte;
  } spfa_req_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] flash_addr;
    logic              send_addr;
    logic [STAT_W-1:0] reg_value;
    logic              send_reg_value;
    logic [OFF_W-1:0]  data_offset;
    logic              send_data;
    logic              read_status;
    logic              done_res;
    logic [1:0]        outcome;
  } spfa_res_t;

  typedef struct packed {
    logic fire;
    logic emit;
  } spfa_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/spfa_in_stage.sv */
// ----------------------------------------------------------------------------
// spfa_in_stage
// Input register; also forms the estimated sector count of a start length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfa_in_stage
  import spfa_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
  localparam int unsigned QUO_W = LEN_W + 1 - $clog2(SECTOR_BYTES)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire spfa_req_t        req_i,
  input  wire logic             advance_i,
  output logic                  valid_o,
  output spfa_req_t             req_o,
  output logic [QUO_W-1:0]      quo_est_o
);

  localparam int unsigned RECIP   = (1 << RECIP_SHIFT) / SECTOR_BYTES;
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned PROD_W  = LEN_W + RECIP_W;

  logic              valid_q, valid_d;
  spfa_req_t         req_q;
  logic [QUO_W-1:0]  quo_q;
  logic [PROD_W-1:0] prod;
  logic              accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Estimate is the true quotient or one less.
  assign prod = {{RECIP_W{1'b0}}, req_i.image_bytes} * PROD_W'(RECIP);

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      quo_q <= prod[RECIP_SHIFT +: QUO_W];
    end
  end

  assign valid_o   = valid_q;
  assign req_o     = req_q;
  assign quo_est_o = quo_q;

endmodule

`default_nettype wire

/* rtl/core/spfa_seq.sv */
// ----------------------------------------------------------------------------
// spfa_seq
// Run state machine: holds the run state and forms the next frame or completion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfa_seq
  import spfa_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int unsigned MAX_SECTORS  = MAX_SECTORS_DEF,
  parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF,
  localparam int unsigned QUO_W = LEN_W + 1 - $clog2(SECTOR_BYTES)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire spfa_req_t        req_i,
  input  wire logic [QUO_W-1:0] quo_est_i,
  output logic                  emit_o,
  output spfa_res_t             res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SECTORS + 1);
  localparam int unsigned PAIRS = SECTOR_BYTES / 2;
  localparam int unsigned PI_W  = $clog2(PAIRS);
  localparam logic [ADDR_W-1:0] AMASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                        ADDR_W'((64'(1) << ADDR_BITS) - 64'(1));
  localparam logic [ADDR_W-1:0] LOW_CLR = {{(ADDR_W-8){1'b1}}, 8'h00};

  spfa_phase_e       phase_q, phase_d;
  logic [ADDR_W-1:0] run_base_q, run_base_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  sidx_q, sidx_d;
  logic [PI_W-1:0]   pidx_q, pidx_d;

  logic [LEN_W-1:0]  len_part;
  logic [LEN_W-1:0]  rem_est;
  logic              rem_hi;
  logic [LEN_W-1:0]  rem;
  logic [QUO_W:0]    quo;
  logic              bad_len;
  logic [CNT_W:0]    sidx_inc;
  logic [PI_W:0]     pidx_inc;
  logic [ADDR_W-1:0] sec_addr;
  logic [OFF_W-1:0]  sec_off;
  logic [OFF_W-1:0]  doff_next;
  logic              busy;

  // Length check: correct the estimated quotient by one step.
  assign len_part = LEN_W'(quo_est_i) * LEN_W'(SECTOR_BYTES);
  assign rem_est  = req_i.image_bytes - len_part;
  assign rem_hi   = rem_est >= LEN_W'(SECTOR_BYTES);
  assign rem      = rem_hi ? rem_est - LEN_W'(SECTOR_BYTES) : rem_est;
  assign quo      = (QUO_W+1)'(quo_est_i) + (QUO_W+1)'(rem_hi);
  assign bad_len  = (rem != '0) || (32'(quo) > 32'(MAX_SECTORS));

  assign sidx_inc  = (CNT_W+1)'(sidx_q) + (CNT_W+1)'(1);
  assign pidx_inc  = (PI_W+1)'(pidx_q) + (PI_W+1)'(1);
  assign sec_addr  = (run_base_q + ADDR_W'(sidx_q) * ADDR_W'(SECTOR_BYTES)) & AMASK & LOW_CLR;
  assign sec_off   = OFF_W'(sidx_q) * OFF_W'(SECTOR_BYTES);
  assign doff_next = sec_off + (OFF_W'(pidx_inc) << 1);
  assign busy      = req_i.status_byte[STATUS_BUSY_BIT];

  always_comb begin
    phase_d    = phase_q;
    run_base_d = run_base_q;
    total_d    = total_q;
    sidx_d     = sidx_q;
    pidx_d     = pidx_q;
    emit_o     = 1'b0;
    res_o      = '0;
    if (fire_i) begin
      if (req_i.action == ACT_START) begin
        run_base_d = req_i.base_addr;
        sidx_d     = '0;
        pidx_d     = '0;
        emit_o     = 1'b1;
        if (bad_len) begin
          total_d        = '0;
          phase_d        = PH_IDLE;
          res_o.done_res = 1'b1;
          res_o.outcome  = OUT_BAD_LEN;
        end else begin
          total_d      = CNT_W'(quo);
          phase_d      = PH_U_EWSR;
          res_o.opcode = OP_EWSR;
        end
      end else if (phase_q != PH_IDLE) begin
        emit_o = 1'b1;
        if (req_i.link_error) begin
          phase_d        = PH_IDLE;
          res_o.done_res = 1'b1;
          res_o.outcome  = OUT_LINK_ERR;
        end else begin
          case (phase_q)
            PH_U_EWSR: begin
              phase_d              = PH_U_WRSR;
              res_o.opcode         = OP_WRSR;
              res_o.reg_value      = SR_UNLOCK;
              res_o.send_reg_value = 1'b1;
            end
            PH_U_WRSR: begin
              if (total_q == '0) begin
                phase_d      = PH_L_EWSR;
                res_o.opcode = OP_EWSR;
              end else begin
                sidx_d       = '0;
                phase_d      = PH_E_WREN;
                res_o.opcode = OP_WREN;
              end
            end
            PH_E_WREN: begin
              phase_d          = PH_E_ERASE;
              res_o.opcode     = OP_SERASE;
              res_o.flash_addr = sec_addr;
              res_o.send_addr  = 1'b1;
            end
            PH_E_ERASE: begin
              phase_d           = PH_E_POLL;
              res_o.opcode      = OP_RDSR;
              res_o.read_status = 1'b1;
            end
            PH_E_POLL: begin
              if (busy) begin
                res_o.opcode      = OP_RDSR;
                res_o.read_status = 1'b1;
              end else if (sidx_inc < (CNT_W+1)'(total_q)) begin
                sidx_d       = CNT_W'(sidx_inc);
                phase_d      = PH_E_WREN;
                res_o.opcode = OP_WREN;
              end else begin
                sidx_d       = total_q - CNT_W'(1);
                phase_d      = PH_P_WREN;
                res_o.opcode = OP_WREN;
              end
            end
            PH_P_WREN: begin
              pidx_d            = '0;
              phase_d           = PH_P_AAI;
              res_o.opcode      = OP_AAI;
              res_o.flash_addr  = sec_addr;
              res_o.send_addr   = 1'b1;
              res_o.data_offset = sec_off;
              res_o.send_data   = 1'b1;
            end
            PH_P_AAI: begin
              phase_d           = PH_P_POLL;
              res_o.opcode      = OP_RDSR;
              res_o.read_status = 1'b1;
            end
            PH_P_POLL: begin
              if (busy) begin
                res_o.opcode      = OP_RDSR;
                res_o.read_status = 1'b1;
              end else if (32'(pidx_inc) < 32'(PAIRS)) begin
                pidx_d            = PI_W'(pidx_inc);
                phase_d           = PH_P_AAI;
                res_o.opcode      = OP_AAI;
                res_o.data_offset = doff_next;
                res_o.send_data   = 1'b1;
              end else begin
                pidx_d       = '0;
                phase_d      = PH_P_WRDI;
                res_o.opcode = OP_WRDI;
              end
            end
            PH_P_WRDI: begin
              if (sidx_q == '0) begin
                phase_d      = PH_L_EWSR;
                res_o.opcode = OP_EWSR;
              end else begin
                sidx_d       = sidx_q - CNT_W'(1);
                phase_d      = PH_P_WREN;
                res_o.opcode = OP_WREN;
              end
            end
            PH_L_EWSR: begin
              phase_d              = PH_L_WRSR;
              res_o.opcode         = OP_WRSR;
              res_o.reg_value      = SR_LOCK;
              res_o.send_reg_value = 1'b1;
            end
            PH_L_WRSR: begin
              phase_d        = PH_IDLE;
              res_o.done_res = 1'b1;
              res_o.outcome  = OUT_OK;
            end
            default: begin
              phase_d = PH_IDLE;
              emit_o  = 1'b0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      run_base_q <= '0;
      total_q    <= '0;
      sidx_q     <= '0;
      pidx_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      run_base_q <= run_base_d;
      total_q    <= total_d;
      sidx_q     <= sidx_d;
      pidx_q     <= pidx_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/spfa_out_stage.sv */
// ----------------------------------------------------------------------------
// spfa_out_stage
// Result register toward the frame engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfa_out_stage
  import spfa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      src_valid_i,
  input  wire spfa_ctl_t ctl_i,
  input  wire spfa_res_t res_i,
  output logic           advance_o,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output spfa_res_t      res_o
);

  logic      valid_q, valid_d;
  spfa_res_t res_q;
  logic      can_load;

  // Load when empty or when the held result leaves this cycle.
  assign can_load  = !valid_q || !out_stall_i;
  assign advance_o = src_valid_i && can_load;

  always_comb begin
    valid_d = valid_q;
    if (can_load) begin
      valid_d = ctl_i.fire && ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fire && ctl_i.emit) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* rtl/core/spi_flash_aai_program_sequencer.sv */
// ----------------------------------------------------------------------------
// spi_flash_aai_program_sequencer
// Sequencer for SPI NOR programming: unlock, sector erase, AAI program, relock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): a start transfer (action 0) opens
//   a run with base_addr_i and image_bytes_i; a response transfer (action 1)
//   reports link_error_i and status_byte_i for the frame last sent.
//   Output channel (out_valid_o / out_stall_i): one result per start and per
//   response during a run, either the next SPI frame or a completion with
//   outcome_o. Responses while idle give no result.
//   Path: a result passes the input register, then the result register.
//   Throughput: one transfer per cycle while in_stall_o is low; the state
//   update of one item completes in the cycle it leaves the input register.
//   Stall: while out_stall_i holds a result, the input register keeps its item
//   and in_stall_o rises only if that register is full.
//   Reset: the sequencer returns to idle with no run open; both registers are
//   empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spi_flash_aai_program_sequencer
  import spfa_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int unsigned MAX_SECTORS  = MAX_SECTORS_DEF,
  parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              action_i,
  input  wire logic [ADDR_W-1:0] base_addr_i,
  input  wire logic [LEN_W-1:0]  image_bytes_i,
  input  wire logic              link_error_i,
  input  wire logic [STAT_W-1:0] status_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [OP_W-1:0]        opcode_o,
  output logic [ADDR_W-1:0]      flash_addr_o,
  output logic                   send_addr_o,
  output logic [STAT_W-1:0]      reg_value_o,
  output logic                   send_reg_value_o,
  output logic [OFF_W-1:0]       data_offset_o,
  output logic                   send_data_o,
  output logic                   read_status_o,
  output logic                   done_res_o,
  output logic [1:0]             outcome_o
);

  localparam int unsigned QUO_W = LEN_W + 1 - $clog2(SECTOR_BYTES);

  spfa_req_t        req_in;
  spfa_req_t        req_s1;
  logic             s1_valid;
  logic [QUO_W-1:0] quo_est;
  logic             advance;
  logic             emit;
  spfa_ctl_t        ctl;
  spfa_res_t        seq_res;
  spfa_res_t        out_res;

  assign req_in.action      = action_i;
  assign req_in.base_addr   = base_addr_i;
  assign req_in.image_bytes = image_bytes_i;
  assign req_in.link_error  = link_error_i;
  assign req_in.status_byte = status_byte_i;

  spfa_in_stage #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (req_in),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .req_o      (req_s1),
    .quo_est_o  (quo_est)
  );

  spfa_seq #(
    .SECTOR_BYTES(SECTOR_BYTES),
    .MAX_SECTORS (MAX_SECTORS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .req_i     (req_s1),
    .quo_est_i (quo_est),
    .emit_o    (emit),
    .res_o     (seq_res)
  );

  assign ctl.fire = advance;
  assign ctl.emit = emit;

  spfa_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (s1_valid),
    .ctl_i       (ctl),
    .res_i       (seq_res),
    .advance_o   (advance),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign opcode_o         = out_res.opcode;
  assign flash_addr_o     = out_res.flash_addr;
  assign send_addr_o      = out_res.send_addr;
  assign reg_value_o      = out_res.reg_value;
  assign send_reg_value_o = out_res.send_reg_value;
  assign data_offset_o    = out_res.data_offset;
  assign send_data_o      = out_res.send_data;
  assign read_status_o    = out_res.read_status;
  assign done_res_o       = out_res.done_res;
  assign outcome_o        = out_res.outcome;

  a_done_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> opcode_o == '0 && !send_addr_o && !send_data_o &&
      !send_reg_value_o && !read_status_o)
    else $error("completion carries frame content");

  a_frame_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> outcome_o == OUT_OK)
    else $error("frame carries an outcome");

  a_addr_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> flash_addr_o[7:0] == 8'h00)
    else $error("address low byte not clear");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid && out_valid_o && out_stall_i)
    else $error("input stalled with room ahead");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SPI flash AAI program sequencer. A predictor
// tracks the run state and works out the frame or completion each transfer
// should produce. A short table covers bad lengths, transfer errors, the zero
// length run, busy polls, address wrap and a restart. Random runs follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import spfa_pkg::*;

  localparam int unsigned LIMIT       = 600_000;
  localparam int unsigned ITEMS       = 800;
  localparam int unsigned PAIRS       = SECTOR_BYTES_DEF / 2;
  localparam int          HOLD_CYCLES = 64;
  localparam spfa_res_t   NO_RES      = '0;

  typedef struct {
    spfa_req_t req;
    bit        typed;
    spfa_res_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              action = 1'b0;
  logic [ADDR_W-1:0] base_addr = '0;
  logic [LEN_W-1:0]  image_bytes = '0;
  logic              link_error = 1'b0;
  logic [STAT_W-1:0] status_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OP_W-1:0]   opcode;
  logic [ADDR_W-1:0] flash_addr;
  logic              send_addr;
  logic [STAT_W-1:0] reg_value;
  logic              send_reg_value;
  logic [OFF_W-1:0]  data_offset;
  logic              send_data;
  logic              read_status;
  logic              done_res;
  logic [1:0]        outcome;

  // predictor state
  spfa_phase_e       seq_phase = PH_IDLE;
  logic [ADDR_W-1:0] run_base = '0;
  int unsigned       sector_count = 0;
  int unsigned       sector_idx = 0;
  int unsigned       pair_idx = 0;

  spfa_res_t   pending_frames[$];
  int unsigned cycles = 0;
  int unsigned accepted = 0;
  int unsigned produced = 0;
  int unsigned errors = 0;
  int unsigned frames_seen = 0;
  int unsigned aai_seen = 0;
  int unsigned done_seen[3] = '{0, 0, 0};
  int unsigned in_stall_edges = 0;
  bit          calm = 1'b0;
  bit          hold_now = 1'b0;

  spi_flash_aai_program_sequencer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (action),
    .base_addr_i     (base_addr),
    .image_bytes_i   (image_bytes),
    .link_error_i    (link_error),
    .status_byte_i   (status_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .opcode_o        (opcode),
    .flash_addr_o    (flash_addr),
    .send_addr_o     (send_addr),
    .reg_value_o     (reg_value),
    .send_reg_value_o(send_reg_value),
    .data_offset_o   (data_offset),
    .send_data_o     (send_data),
    .read_status_o   (read_status),
    .done_res_o      (done_res),
    .outcome_o       (outcome)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_frames.size());
      $display("spi_flash_aai_program_sequencer regression: fail");
      $finish;
    end
  end

  function automatic spfa_res_t plain_op(input logic [OP_W-1:0] op);
    spfa_res_t r;
    r = '0;
    r.opcode = op;
    return r;
  endfunction

  function automatic spfa_res_t wrsr_word(input logic [STAT_W-1:0] v);
    spfa_res_t r;
    r = plain_op(OP_WRSR);
    r.reg_value = v;
    r.send_reg_value = 1'b1;
    return r;
  endfunction

  function automatic spfa_res_t done_word(input logic [1:0] oc);
    spfa_res_t r;
    r = '0;
    r.done_res = 1'b1;
    r.outcome = oc;
    return r;
  endfunction

  function automatic spfa_req_t start_req(input logic [ADDR_W-1:0] base,
                                          input logic [LEN_W-1:0] len);
    spfa_req_t r;
    r.action = ACT_START;
    r.base_addr = base;
    r.image_bytes = len;
    r.link_error = 1'($urandom_range(0, 1));
    r.status_byte = STAT_W'($urandom);
    return r;
  endfunction

  function automatic spfa_req_t resp_req(input logic lerr, input logic [STAT_W-1:0] st);
    spfa_req_t r;
    r.action = ~ACT_START;
    r.base_addr = ADDR_W'($urandom);
    r.image_bytes = LEN_W'($urandom);
    r.link_error = lerr;
    r.status_byte = st;
    return r;
  endfunction

  function automatic logic [STAT_W-1:0] poll_status(input int busy_pct);
    logic [STAT_W-1:0] s;
    s = STAT_W'($urandom);
    s[STATUS_BUSY_BIT] = ($urandom_range(0, 99) < busy_pct);
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] sector_base();
    logic [63:0] a;
    a = 64'(run_base) + 64'(sector_idx) * 64'(SECTOR_BYTES_DEF);
    a = a & ((64'd1 << ADDR_BITS_DEF) - 64'd1);
    return a[ADDR_W-1:0] & ~ADDR_W'(8'hFF);
  endfunction

  function automatic logic [OFF_W-1:0] pair_offset();
    return OFF_W'(sector_idx * SECTOR_BYTES_DEF + pair_idx * 2);
  endfunction

  // Advance the predicted run by one transfer; return 1 if it yields a result.
  function automatic bit next_frame(input spfa_req_t r, output spfa_res_t res);
    bit busy;
    res = '0;
    busy = r.status_byte[STATUS_BUSY_BIT];
    if (r.action == ACT_START) begin
      run_base = r.base_addr;
      sector_idx = 0;
      pair_idx = 0;
      if ((r.image_bytes % SECTOR_BYTES_DEF) != 0 ||
          (r.image_bytes / SECTOR_BYTES_DEF) > MAX_SECTORS_DEF) begin
        sector_count = 0;
        res = done_word(OUT_BAD_LEN);
        seq_phase = PH_IDLE;
        return 1'b1;
      end
      sector_count = r.image_bytes / SECTOR_BYTES_DEF;
      res.opcode = OP_EWSR;
      seq_phase = PH_U_EWSR;
      return 1'b1;
    end
    if (seq_phase == PH_IDLE) return 1'b0;
    if (r.link_error) begin
      res = done_word(OUT_LINK_ERR);
      seq_phase = PH_IDLE;
      return 1'b1;
    end
    case (seq_phase)
      PH_U_EWSR: begin
        res = wrsr_word(SR_UNLOCK);
        seq_phase = PH_U_WRSR;
      end
      PH_U_WRSR: begin
        if (sector_count == 0) begin
          res.opcode = OP_EWSR;
          seq_phase = PH_L_EWSR;
        end else begin
          sector_idx = 0;
          res.opcode = OP_WREN;
          seq_phase = PH_E_WREN;
        end
      end
      PH_E_WREN: begin
        res.opcode = OP_SERASE;
        res.flash_addr = sector_base();
        res.send_addr = 1'b1;
        seq_phase = PH_E_ERASE;
      end
      PH_E_ERASE: begin
        res.opcode = OP_RDSR;
        res.read_status = 1'b1;
        seq_phase = PH_E_POLL;
      end
      PH_E_POLL: begin
        if (busy) begin
          res.opcode = OP_RDSR;
          res.read_status = 1'b1;
        end else begin
          sector_idx++;
          res.opcode = OP_WREN;
          if (sector_idx < sector_count) begin
            seq_phase = PH_E_WREN;
          end else begin
            sector_idx = sector_count - 1;
            seq_phase = PH_P_WREN;
          end
        end
      end
      PH_P_WREN: begin
        pair_idx = 0;
        res.opcode = OP_AAI;
        res.flash_addr = sector_base();
        res.send_addr = 1'b1;
        res.data_offset = pair_offset();
        res.send_data = 1'b1;
        seq_phase = PH_P_AAI;
      end
      PH_P_AAI: begin
        res.opcode = OP_RDSR;
        res.read_status = 1'b1;
        seq_phase = PH_P_POLL;
      end
      PH_P_POLL: begin
        if (busy) begin
          res.opcode = OP_RDSR;
          res.read_status = 1'b1;
        end else begin
          pair_idx++;
          if (pair_idx < PAIRS) begin
            res.opcode = OP_AAI;
            res.data_offset = pair_offset();
            res.send_data = 1'b1;
            seq_phase = PH_P_AAI;
          end else begin
            pair_idx = 0;
            res.opcode = OP_WRDI;
            seq_phase = PH_P_WRDI;
          end
        end
      end
      PH_P_WRDI: begin
        if (sector_idx == 0) begin
          res.opcode = OP_EWSR;
          seq_phase = PH_L_EWSR;
        end else begin
          sector_idx--;
          res.opcode = OP_WREN;
          seq_phase = PH_P_WREN;
        end
      end
      PH_L_EWSR: begin
        res = wrsr_word(SR_LOCK);
        seq_phase = PH_L_WRSR;
      end
      PH_L_WRSR: begin
        res = done_word(OUT_OK);
        seq_phase = PH_IDLE;
      end
      default: begin
        seq_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // Offer one item, hold it until the transfer, then record its expectation.
  task automatic offer(input spfa_req_t r, input bit typed, input spfa_res_t want);
    spfa_res_t pred;
    if (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= r.action;
    base_addr <= r.base_addr;
    image_bytes <= r.image_bytes;
    link_error <= r.link_error;
    status_byte <= r.status_byte;
    do @(posedge clk); while (in_stall);
    accepted++;
    calm = (accepted >= 400 && accepted < 700);
    if (next_frame(r, pred)) begin
      pending_frames.push_back(typed ? want : pred);
      produced++;
    end
  endtask

  task automatic drive_run(input logic [ADDR_W-1:0] base, input logic [LEN_W-1:0] len,
                           input int max_resp, input int err_pm, input int busy_pct);
    offer(start_req(base, len), 1'b0, NO_RES);
    for (int k = 0; k < max_resp && seq_phase != PH_IDLE && accepted < ITEMS; k++) begin
      offer(resp_req($urandom_range(0, 999) < err_pm, poll_status(busy_pct)), 1'b0, NO_RES);
    end
  endtask

  // receiver side
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        hold_now = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 13);
      end
    end
  end

  always @(posedge clk) begin
    spfa_res_t got;
    spfa_res_t want;
    string     diff;
    if (rst_n && in_valid && in_stall) in_stall_edges++;
    if (rst_n && out_valid && !out_stall) begin
      got = '{opcode, flash_addr, send_addr, reg_value, send_reg_value,
              data_offset, send_data, read_status, done_res, outcome};
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_frames.pop_front();
        diff = "";
        if (got.opcode !== want.opcode) diff = {diff, " opcode"};
        if (got.flash_addr !== want.flash_addr) diff = {diff, " flash_addr"};
        if (got.send_addr !== want.send_addr) diff = {diff, " send_addr"};
        if (got.reg_value !== want.reg_value) diff = {diff, " reg_value"};
        if (got.send_reg_value !== want.send_reg_value) diff = {diff, " send_reg_value"};
        if (got.data_offset !== want.data_offset) diff = {diff, " data_offset"};
        if (got.send_data !== want.send_data) diff = {diff, " send_data"};
        if (got.read_status !== want.read_status) diff = {diff, " read_status"};
        if (got.done_res !== want.done_res) diff = {diff, " done_res"};
        if (got.outcome !== want.outcome) diff = {diff, " outcome"};
        if (diff != "") begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at cycle %0d in%s", cycles, diff);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
        if (want.done_res) begin
          if (want.outcome <= OUT_LINK_ERR) done_seen[want.outcome]++;
        end else begin
          frames_seen++;
          if (want.opcode == OP_AAI) aai_seen++;
        end
      end
    end
  end

  initial begin
    dir_row_t          dir_rows[$];
    int                pick;
    int                iter;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] base;

    dir_rows = '{
      '{resp_req(1'b1, 8'hFF), 1'b0, NO_RES},
      '{start_req(24'h000000, 23'd4097), 1'b1, done_word(OUT_BAD_LEN)},
      '{start_req(24'hFFFFFF, 23'h3FFFFF), 1'b1, done_word(OUT_BAD_LEN)},
      '{start_req(24'h000000, 23'd4194304), 1'b1, plain_op(OP_EWSR)},
      '{resp_req(1'b1, 8'h00), 1'b1, done_word(OUT_LINK_ERR)},
      '{start_req(24'hABCDEF, 23'd0), 1'b1, plain_op(OP_EWSR)},
      '{resp_req(1'b0, 8'h01), 1'b1, wrsr_word(SR_UNLOCK)},
      '{resp_req(1'b0, 8'hFF), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'hFF), 1'b1, wrsr_word(SR_LOCK)},
      '{resp_req(1'b0, 8'h00), 1'b1, done_word(OUT_OK)},
      '{start_req(24'hFFFF80, 23'd8192), 1'b1, plain_op(OP_EWSR)},
      '{resp_req(1'b0, 8'h00), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'h00), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'hFF), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'h00), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'h01), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'hFE), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'h00), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'h00), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'h00), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'h00), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'h00), 1'b0, NO_RES},
      '{resp_req(1'b0, 8'h00), 1'b0, NO_RES},
      '{start_req(24'h123456, 23'd4096), 1'b1, plain_op(OP_EWSR)},
      '{resp_req(1'b1, 8'h01), 1'b1, done_word(OUT_LINK_ERR)}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    iter = 0;
    while (accepted < ITEMS) begin
      iter++;
      if (iter == 6) hold_now = 1'b1;
      pick = $urandom_range(0, 9);
      base = ADDR_W'($urandom);
      case (pick)
        0: offer(resp_req(1'($urandom_range(0, 1)), STAT_W'($urandom)), 1'b0, NO_RES);
        1: begin
          len = LEN_W'($urandom_range(1, 4194303));
          if (len % SECTOR_BYTES_DEF == 0) len = len + LEN_W'(1);
          offer(start_req(base, len), 1'b0, NO_RES);
        end
        2: drive_run(base, '0, 10, 50, 30);
        3, 4, 5, 6: drive_run(base, LEN_W'($urandom_range(1, 4) * SECTOR_BYTES_DEF),
                              $urandom_range(5, 60), 20, 30);
        7: begin
          len = ($urandom_range(0, 3) == 0) ? LEN_W'(4194304)
                : LEN_W'($urandom_range(5, 1024) * SECTOR_BYTES_DEF);
          drive_run(base, len, $urandom_range(10, 40), 10, 30);
        end
        8: drive_run(base, LEN_W'($urandom_range(1, 3) * SECTOR_BYTES_DEF),
                     $urandom_range(100, 300), 0, 30);
        default: drive_run(base, LEN_W'($urandom_range(1, 2) * SECTOR_BYTES_DEF),
                           $urandom_range(50, 400), 5, 20);
      endcase
    end

    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d transfers, %0d results, %0d frames (%0d AAI)",
             accepted, produced, frames_seen, aai_seen);
    $display("completions ok/bad length/link error %0d/%0d/%0d, input held off on %0d edges",
             done_seen[0], done_seen[1], done_seen[2], in_stall_edges);
    if (errors == 0) begin
      $display("spi_flash_aai_program_sequencer regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("spi_flash_aai_program_sequencer regression: fail");
    end
    $finish;
  end

endmodule
